[design/gpc_pkg.sv]
// Shared types, register offsets and pin constants for the GPIO controller.
package gpc_pkg;

    // Number of pins that exist; bits at or above it read and store as zero
    localparam int PIN_COUNT = 32;
    localparam int DATA_W    = 32;
    localparam int OFF_W     = 8;
    localparam int PIN_IDX_W = 5;

    localparam logic [DATA_W-1:0] PIN_MASK =
        (PIN_COUNT >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

    // Register byte offsets
    localparam logic [OFF_W-1:0] OFF_DIR    = 8'd0;
    localparam logic [OFF_W-1:0] OFF_OUT    = 8'd4;
    localparam logic [OFF_W-1:0] OFF_IN     = 8'd8;
    localparam logic [OFF_W-1:0] OFF_IE     = 8'd12;
    localparam logic [OFF_W-1:0] OFF_STATUS = 8'd16;
    localparam logic [OFF_W-1:0] OFF_TRIG   = 8'd20;
    localparam logic [OFF_W-1:0] OFF_POL    = 8'd24;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_PIN   = 2'd2,
        REQ_NOP   = 2'd3
    } req_kind_t;

    // One request as held in the input register
    typedef struct packed {
        req_kind_t              req_type;
        logic [OFF_W-1:0]       reg_offset;
        logic [DATA_W-1:0]      data_value;
        logic [PIN_IDX_W-1:0]   pin_index;
    } req_t;

    // One response as held in the output register
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pending;
        logic [DATA_W-1:0] pin_out_values;
        logic [DATA_W-1:0] pin_out_enable;
        logic              access_error;
    } rsp_t;

endpackage

[design/gpc_core.sv]
// GPIO register file, pin level update and interrupt status logic.
module gpc_core
    import gpc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic process,
    input  req_t req,
    output rsp_t rsp
);

    logic [DATA_W-1:0] direction_reg, direction_next;
    logic [DATA_W-1:0] output_reg, output_next;
    logic [DATA_W-1:0] enable_reg, enable_next;
    logic [DATA_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] trigger_reg, trigger_next;
    logic [DATA_W-1:0] polarity_reg, polarity_next;
    logic [DATA_W-1:0] levels_reg, levels_next;
    logic [DATA_W-1:0] driven_reg, driven_next;
    logic [DATA_W-1:0] external_reg, external_next;

    logic [DATA_W-1:0] rd;
    logic              err;
    logic              run;
    logic              pin_ok;
    logic [DATA_W-1:0] pin_bit;
    logic [DATA_W-1:0] lev, match, rise, fall, edge_hit, st;

    assign pin_ok  = (int'(req.pin_index) < PIN_COUNT);
    assign pin_bit = DATA_W'(1) << req.pin_index;

    // Register access / pin event decode, then pin update on the new values
    always_comb begin
        direction_next = direction_reg;
        output_next    = output_reg;
        enable_next    = enable_reg;
        status_next    = status_reg;
        trigger_next   = trigger_reg;
        polarity_next  = polarity_reg;
        levels_next    = levels_reg;
        driven_next    = driven_reg;
        external_next  = external_reg;
        rd             = '0;
        err            = 1'b0;
        run            = 1'b0;
        lev            = '0;
        match          = '0;
        rise           = '0;
        fall           = '0;
        edge_hit       = '0;
        st             = '0;

        case (req.req_type)
            REQ_READ: begin
                case (req.reg_offset)
                    OFF_DIR:    rd = direction_reg;
                    OFF_OUT:    rd = output_reg;
                    OFF_IN:     rd = levels_reg;
                    OFF_IE:     rd = enable_reg;
                    OFF_STATUS: rd = status_reg;
                    OFF_TRIG:   rd = trigger_reg;
                    OFF_POL:    rd = polarity_reg;
                    default:    err = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                run = 1'b1;
                case (req.reg_offset)
                    OFF_DIR:    direction_next = req.data_value & PIN_MASK;
                    OFF_OUT:    output_next    = req.data_value & PIN_MASK;
                    OFF_IN:     err = 1'b1;  // read-only, but pins still update
                    OFF_IE:     enable_next    = req.data_value & PIN_MASK;
                    OFF_STATUS: status_next    = status_reg & ~req.data_value;
                    OFF_TRIG:   trigger_next   = req.data_value & PIN_MASK;
                    OFF_POL:    polarity_next  = req.data_value & PIN_MASK;
                    default: begin
                        err = 1'b1;
                        run = 1'b0;
                    end
                endcase
            end
            REQ_PIN: begin
                if (pin_ok) begin
                    run = 1'b1;
                    if (req.data_value[1]) begin
                        driven_next = driven_reg & ~pin_bit;
                    end else begin
                        driven_next = driven_reg | pin_bit;
                        if (req.data_value[0]) begin
                            external_next = external_reg | pin_bit;
                        end else begin
                            external_next = external_reg & ~pin_bit;
                        end
                    end
                end
            end
            default: ;
        endcase

        // Pin levels and per-pin level / edge detection
        if (run) begin
            lev = ((direction_next & output_next) |
                   (~direction_next & driven_next & external_next)) & PIN_MASK;
            match    = ~(lev ^ polarity_next);
            rise     = lev & ~levels_reg;
            fall     = ~lev & levels_reg;
            edge_hit = (polarity_next & rise) | (~polarity_next & fall);
            st       = status_next;
            st       = st | (trigger_next & match & enable_next);
            st       = st & ~(trigger_next & ~match);
            st       = st | (~trigger_next & edge_hit & enable_next);
            status_next = st & PIN_MASK;
            levels_next = lev;
        end
    end

    // Response fields, from the state after this transaction
    always_comb begin
        rsp.read_data      = rd;
        rsp.irq_pending    = |(status_next & enable_next);
        rsp.pin_out_values = output_next & direction_next;
        rsp.pin_out_enable = direction_next;
        rsp.access_error   = err;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= '0;
            output_reg    <= '0;
            enable_reg    <= '0;
            status_reg    <= '0;
            trigger_reg   <= '0;
            polarity_reg  <= '0;
            levels_reg    <= '0;
            driven_reg    <= '0;
            external_reg  <= '0;
        end else if (process) begin
            direction_reg <= direction_next;
            output_reg    <= output_next;
            enable_reg    <= enable_next;
            status_reg    <= status_next;
            trigger_reg   <= trigger_next;
            polarity_reg  <= polarity_next;
            levels_reg    <= levels_next;
            driven_reg    <= driven_next;
            external_reg  <= external_next;
        end
    end

    // Output pins always show their output bit on the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (levels_reg & direction_reg) == (output_reg & direction_reg))
        else $error("output pin level differs from output data");

    // A newly set status bit needs its enable
    assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> ((status_reg & ~$past(status_reg) & ~enable_reg) == '0))
        else $error("status bit set on a disabled pin");

    // Reads leave the state alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        process && req.req_type == REQ_READ |=>
            $stable(status_reg) && $stable(levels_reg) && $stable(direction_reg))
        else $error("read transaction changed state");

endmodule

[design/gpio_controller_with_pin_interrupts.sv]
// Top level of the GPIO controller: input register, core logic and result register.
//
//  channel  dir  tdata (low bit up)                                    tuser
//  s_       in   reg_offset[7:0] data_value[39:8] pin_index[44:40]     req_type[1:0]
//  m_       out  read_data[31:0] irq_pending[32] pin_out_values[64:33]  -
//                pin_out_enable[96:65] access_error[97]
//
//  One transaction per cycle unless m_ stalls; m_tvalid is set via input and result registers.
//  The input register feeds single-pass decode and pin update logic into the result register.
//  A stalled m_ side holds the result register; s_tready stays high while a slot is free.
//  aresetn is synchronous, active low, and clears all GPIO state to zero.
module gpio_controller_with_pin_interrupts
    import gpc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // reg_offset, data_value, pin_index, zero pad
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // read_data, irq_pending, pin_out_values,
                                    // pin_out_enable, access_error, zero pad
);

    logic in_valid_reg;
    req_t in_req_reg;
    logic out_valid_reg;
    rsp_t out_rsp_reg;
    logic advance;
    logic process;
    rsp_t rsp;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg.req_type   <= req_kind_t'(s_tuser);
            in_req_reg.reg_offset <= s_tdata[7:0];
            in_req_reg.data_value <= s_tdata[39:8];
            in_req_reg.pin_index  <= s_tdata[44:40];
        end
    end

    gpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .process (process),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_rsp_reg.access_error,
                       out_rsp_reg.pin_out_enable,
                       out_rsp_reg.pin_out_values,
                       out_rsp_reg.irq_pending,
                       out_rsp_reg.read_data};

endmodule
